[sv/stok_pkg.sv]
package stok_pkg;

    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = 16'hFFFF;
    localparam int WORD_BITS = 48;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_NUM   = 3'd2,
        MODE_STR   = 3'd3,
        MODE_MINUS = 3'd4,
        MODE_DROP  = 3'd5
    } t_mode;

    typedef enum logic [4:0] {
        KIND_IDENT  = 5'd0,
        KIND_NUM    = 5'd1,
        KIND_STRING = 5'd2,
        KIND_LPAREN = 5'd3,
        KIND_RPAREN = 5'd4,
        KIND_LBRACE = 5'd5,
        KIND_RBRACE = 5'd6,
        KIND_SEMI   = 5'd7,
        KIND_STAR   = 5'd8,
        KIND_PLUS   = 5'd9,
        KIND_SLASH  = 5'd10,
        KIND_PCT    = 5'd11,
        KIND_EQ     = 5'd12,
        KIND_MINUS  = 5'd13,
        KIND_ARROW  = 5'd14,
        KIND_IF     = 5'd15,
        KIND_ELSE   = 5'd16,
        KIND_FN     = 5'd17,
        KIND_FOR    = 5'd18,
        KIND_WHILE  = 5'd19,
        KIND_VAR    = 5'd20,
        KIND_RETURN = 5'd21,
        KIND_END    = 5'd22,
        KIND_ERROR  = 5'd23
    } t_tok_type;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    localparam logic [WORD_BITS-1:0] KW_IF     = 48'h0000_0000_6669;
    localparam logic [WORD_BITS-1:0] KW_ELSE   = 48'h0000_6573_6C65;
    localparam logic [WORD_BITS-1:0] KW_FN     = 48'h0000_0000_6E66;
    localparam logic [WORD_BITS-1:0] KW_FOR    = 48'h0000_0072_6F66;
    localparam logic [WORD_BITS-1:0] KW_WHILE  = 48'h0065_6C69_6877;
    localparam logic [WORD_BITS-1:0] KW_VAR    = 48'h0000_0072_6176;
    localparam logic [WORD_BITS-1:0] KW_RETURN = 48'h6E72_7574_6572;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        logic r;
        case (c)
            8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B, 8'h2A, 8'h2B, 8'h2F, 8'h25, 8'h3D: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_tok_type single_type(input logic [7:0] c);
        t_tok_type t;
        case (c)
            8'h28:   t = KIND_LPAREN;
            8'h29:   t = KIND_RPAREN;
            8'h7B:   t = KIND_LBRACE;
            8'h7D:   t = KIND_RBRACE;
            8'h3B:   t = KIND_SEMI;
            8'h2A:   t = KIND_STAR;
            8'h2B:   t = KIND_PLUS;
            8'h2F:   t = KIND_SLASH;
            8'h25:   t = KIND_PCT;
            8'h3D:   t = KIND_EQ;
            default: t = KIND_ERROR;
        endcase
        return t;
    endfunction

    function automatic t_tok_type word_type(input logic [WORD_BITS-1:0] w,
                                            input logic [2:0] n);
        t_tok_type t;
        t = KIND_IDENT;
        if (n == 3'd2 && w == KW_IF)          t = KIND_IF;
        else if (n == 3'd4 && w == KW_ELSE)   t = KIND_ELSE;
        else if (n == 3'd2 && w == KW_FN)     t = KIND_FN;
        else if (n == 3'd3 && w == KW_FOR)    t = KIND_FOR;
        else if (n == 3'd5 && w == KW_WHILE)  t = KIND_WHILE;
        else if (n == 3'd3 && w == KW_VAR)    t = KIND_VAR;
        else if (n == 3'd6 && w == KW_RETURN) t = KIND_RETURN;
        return t;
    endfunction

endpackage

[sv/source_tokenizer_core.sv]
// A transferred byte is held in the input register until it is scanned, which writes its
// tokens to the result queue; each token then waits in the queue until it transfers.
// Throughput: one byte per cycle; a byte that closes a token and emits a second one
// queues two results, and the input stalls while more than two results wait.
// Reset (synchronous, active low) empties the input register and the 4-entry result
// queue and returns the scanner to idle at byte 0, row 1, column 1.
module source_tokenizer_core
    import stok_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int POS_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_ch,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [4:0]            o_token_type,
    output logic [INDEX_BITS-1:0] o_token_start,
    output logic [LEN_BITS-1:0]   o_token_length,
    output logic [POS_BITS-1:0]   o_token_row,
    output logic [POS_BITS-1:0]   o_token_col,
    output logic                  o_last
);

    localparam int LW = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;
    localparam logic [POS_BITS-1:0]   POS_MAX = '1;
    localparam logic [POS_BITS-1:0]   POS_ONE = POS_BITS'(1);

    typedef struct packed {
        t_tok_type             tok;
        logic [INDEX_BITS-1:0] start;
        logic [LEN_BITS-1:0]   len;
        logic [POS_BITS-1:0]   row;
        logic [POS_BITS-1:0]   col;
        logic                  last;
    } t_rec;

    function automatic logic [LEN_BITS-1:0] span_len(input logic [INDEX_BITS-1:0] e,
                                                     input logic [INDEX_BITS-1:0] s);
        logic [INDEX_BITS-1:0] d;
        logic [LW-1:0]         dw;
        d  = (e >= s) ? e - s : '0;
        dw = LW'(d);
        return (dw > LW'(LEN_MAX)) ? LEN_MAX : dw[LEN_BITS-1:0];
    endfunction

    logic                  r_in_valid;
    logic [7:0]            r_ch;

    t_mode                 r_mode, n_mode;
    logic [WORD_BITS-1:0]  r_word_chars, n_word_chars;
    logic [2:0]            r_word_count, n_word_count;
    logic [INDEX_BITS-1:0] r_text_index, n_text_index;
    logic [POS_BITS-1:0]   r_cur_row, n_cur_row;
    logic [POS_BITS-1:0]   r_cur_col, n_cur_col;
    logic [INDEX_BITS-1:0] r_tok_start, n_tok_start;
    logic [POS_BITS-1:0]   r_tok_row, n_tok_row;
    logic [POS_BITS-1:0]   r_tok_col, n_tok_col;

    t_rec                  r_q [4];
    logic [1:0]            r_wr_ptr, r_rd_ptr;
    logic [2:0]            r_count;

    logic                  in_xfer, proc, pop;
    logic                  emit_a, emit_b, do_idle, restart;
    t_rec                  rec_a, rec_b, res0, res1;
    logic [1:0]            nres;
    logic [INDEX_BITS-1:0] idx_inc;
    logic [POS_BITS-1:0]   col_inc, row_inc;
    logic [LEN_BITS-1:0]   len_cur, len_next;

    assign proc    = r_in_valid && (r_count <= 3'd2);
    assign o_stall = r_in_valid && !proc;
    assign in_xfer = i_valid && !o_stall;
    assign o_valid = (r_count != 3'd0);
    assign pop     = o_valid && !i_stall;

    assign idx_inc  = (r_text_index == IDX_MAX) ? IDX_MAX : r_text_index + INDEX_BITS'(1);
    assign col_inc  = (r_cur_col == POS_MAX) ? POS_MAX : r_cur_col + POS_ONE;
    assign row_inc  = (r_cur_row == POS_MAX) ? POS_MAX : r_cur_row + POS_ONE;
    assign len_cur  = span_len(r_text_index, r_tok_start);
    assign len_next = span_len(idx_inc, r_tok_start);

    always_comb begin
        n_mode       = r_mode;
        n_word_chars = r_word_chars;
        n_word_count = r_word_count;
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_tok_start  = r_tok_start;
        n_tok_row    = r_tok_row;
        n_tok_col    = r_tok_col;
        n_text_index = idx_inc;
        emit_a  = 1'b0;
        emit_b  = 1'b0;
        do_idle = 1'b0;
        restart = 1'b0;
        rec_a   = '{tok: KIND_IDENT, start: r_tok_start, len: len_cur,
                    row: r_tok_row, col: r_tok_col, last: 1'b0};
        rec_b   = '{tok: KIND_ERROR, start: r_text_index, len: LEN_BITS'(1),
                    row: r_cur_row, col: r_cur_col, last: 1'b0};

        case (r_mode)
            MODE_IDENT: begin
                if (is_alpha(r_ch) || is_digit(r_ch)) begin
                    if (r_word_count < 3'd6) begin
                        n_word_chars = r_word_chars
                                       | (WORD_BITS'(r_ch) << {r_word_count, 3'b000});
                        n_word_count = r_word_count + 3'd1;
                    end else begin
                        n_word_count = 3'd7;
                    end
                    n_cur_col = col_inc;
                end else begin
                    emit_a       = 1'b1;
                    rec_a.tok    = word_type(r_word_chars, r_word_count);
                    n_word_chars = '0;
                    n_word_count = '0;
                    do_idle      = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_digit(r_ch)) begin
                    n_cur_col = col_inc;
                end else begin
                    emit_a    = 1'b1;
                    rec_a.tok = KIND_NUM;
                    do_idle   = 1'b1;
                end
            end
            MODE_STR: begin
                if (r_ch == CH_QUOTE) begin
                    n_cur_col = col_inc;
                    emit_a    = 1'b1;
                    rec_a.tok = KIND_STRING;
                    rec_a.len = len_next;
                    n_mode    = MODE_IDLE;
                end else if (r_ch == CH_NUL) begin
                    emit_a    = 1'b1;
                    rec_a.tok = KIND_ERROR;
                    restart   = 1'b1;
                end else begin
                    n_cur_col = col_inc;
                end
            end
            MODE_MINUS: begin
                emit_a = 1'b1;
                if (r_ch == CH_GT) begin
                    n_cur_col = col_inc;
                    rec_a.tok = KIND_ARROW;
                    rec_a.len = len_next;
                    n_mode    = MODE_IDLE;
                end else begin
                    rec_a.tok = KIND_MINUS;
                    rec_a.len = LEN_BITS'(1);
                    do_idle   = 1'b1;
                end
            end
            MODE_DROP: begin
                if (r_ch == CH_NUL) begin
                    restart = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            n_mode = MODE_IDLE;
            if (r_ch == CH_NUL) begin
                emit_b    = 1'b1;
                rec_b.tok = KIND_END;
                rec_b.len = '0;
                restart   = 1'b1;
            end else if (r_ch == CH_SPACE || r_ch == CH_TAB) begin
                n_cur_col = col_inc;
            end else if (r_ch == CH_LF) begin
                n_cur_col = POS_ONE;
                n_cur_row = row_inc;
            end else if (r_ch == CH_CR) begin
                n_cur_col = POS_ONE;
            end else if (is_alpha(r_ch)) begin
                n_tok_start  = r_text_index;
                n_tok_row    = r_cur_row;
                n_tok_col    = r_cur_col;
                n_word_chars = WORD_BITS'(r_ch);
                n_word_count = 3'd1;
                n_mode       = MODE_IDENT;
                n_cur_col    = col_inc;
            end else if (is_digit(r_ch)) begin
                n_tok_start = r_text_index;
                n_tok_row   = r_cur_row;
                n_tok_col   = r_cur_col;
                n_mode      = MODE_NUM;
                n_cur_col   = col_inc;
            end else if (r_ch == CH_QUOTE) begin
                n_cur_col   = col_inc;
                n_tok_start = idx_inc;
                n_tok_row   = r_cur_row;
                n_tok_col   = col_inc;
                n_mode      = MODE_STR;
            end else if (r_ch == CH_DASH) begin
                n_tok_start = r_text_index;
                n_tok_row   = r_cur_row;
                n_tok_col   = r_cur_col;
                n_mode      = MODE_MINUS;
                n_cur_col   = col_inc;
            end else if (is_single(r_ch)) begin
                emit_b    = 1'b1;
                rec_b.tok = single_type(r_ch);
                n_cur_col = col_inc;
            end else begin
                emit_b    = 1'b1;
                rec_b.tok = KIND_ERROR;
                n_mode    = MODE_DROP;
            end
        end

        if (restart) begin
            n_mode       = MODE_IDLE;
            n_word_chars = '0;
            n_word_count = '0;
            n_text_index = '0;
            n_cur_row    = POS_ONE;
            n_cur_col    = POS_ONE;
            n_tok_start  = '0;
            n_tok_row    = POS_ONE;
            n_tok_col    = POS_ONE;
        end

        nres      = {1'b0, emit_a} + {1'b0, emit_b};
        res0      = emit_a ? rec_a : rec_b;
        res0.last = (nres == 2'd1);
        res1      = rec_b;
        res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_mode       <= MODE_IDLE;
            r_word_chars <= '0;
            r_word_count <= '0;
            r_text_index <= '0;
            r_cur_row    <= POS_ONE;
            r_cur_col    <= POS_ONE;
            r_tok_start  <= '0;
            r_tok_row    <= POS_ONE;
            r_tok_col    <= POS_ONE;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_mode       <= n_mode;
                r_word_chars <= n_word_chars;
                r_word_count <= n_word_count;
                r_text_index <= n_text_index;
                r_cur_row    <= n_cur_row;
                r_cur_col    <= n_cur_col;
                r_tok_start  <= n_tok_start;
                r_tok_row    <= n_tok_row;
                r_tok_col    <= n_tok_col;
                r_wr_ptr     <= r_wr_ptr + nres;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (proc ? {1'b0, nres} : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ch <= i_ch;
        end
        if (proc && nres != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (proc && nres == 2'd2) begin
            r_q[r_wr_ptr + 2'd1] <= res1;
        end
    end

    assign o_token_type   = r_q[r_rd_ptr].tok;
    assign o_token_start  = r_q[r_rd_ptr].start;
    assign o_token_length = r_q[r_rd_ptr].len;
    assign o_token_row    = r_q[r_rd_ptr].row;
    assign o_token_col    = r_q[r_rd_ptr].col;
    assign o_last         = r_q[r_rd_ptr].last;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import stok_pkg::*;
();

    localparam int IDX_W = 20;
    localparam int POS_W = 16;

    typedef struct packed {
        t_tok_type        ttype;
        logic [IDX_W-1:0] start;
        logic [15:0]      len;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_tok;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_tok       want;
    } t_byte_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic [7:0]            i_ch = 8'h00;
    logic                  i_stall = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [4:0]            o_token_type;
    logic [IDX_W-1:0]      o_token_start;
    logic [LEN_BITS-1:0]   o_token_length;
    logic [POS_W-1:0]      o_token_row;
    logic [POS_W-1:0]      o_token_col;
    logic                  o_last;

    source_tokenizer_core #(
        .INDEX_BITS (IDX_W),
        .POS_BITS   (POS_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_type   (o_token_type),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_token_row    (o_token_row),
        .o_token_col    (o_token_col),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("tb_top: FAIL");
        $finish;
    end

    string kw_names [7] = '{"if", "else", "fn", "for", "while", "var", "return"};
    string punct_chars = "(){};*+/%=";
    string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

    t_mode            sc_mode;
    logic [47:0]      sc_word;
    logic [2:0]       sc_wcount;
    logic [IDX_W-1:0] sc_index;
    logic [POS_W-1:0] sc_row;
    logic [POS_W-1:0] sc_col;
    logic [IDX_W-1:0] tk_start;
    logic [POS_W-1:0] tk_row;
    logic [POS_W-1:0] tk_col;

    t_tok       step_q [$];
    t_tok       token_q [$];
    t_byte_item byte_q [$];
    t_byte_item cur_item;

    int idle_pct = 33;
    int errs = 0;
    int out_count = 0;
    int rand_bytes = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] v);
        return (v == {IDX_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] v);
        return (v == {POS_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] span_len(input logic [IDX_W-1:0] e);
        logic [IDX_W-1:0] d;
        d = (e >= tk_start) ? e - tk_start : '0;
        return (d > 20'h0FFFF) ? LEN_MAX : d[15:0];
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic t_tok_type punct_code(input logic [7:0] c);
        for (int k = 0; k < punct_chars.len(); k++)
            if (c == punct_chars[k]) return t_tok_type'(KIND_LPAREN + k);
        return KIND_ERROR;
    endfunction

    function automatic logic [47:0] pack_word(input string s);
        logic [47:0] w;
        w = '0;
        for (int i = 0; i < s.len(); i++) w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic t_tok_type word_code();
        for (int k = 0; k < 7; k++)
            if (int'(sc_wcount) == kw_names[k].len() && sc_word == pack_word(kw_names[k]))
                return t_tok_type'(KIND_IF + k);
        return KIND_IDENT;
    endfunction

    function automatic t_byte_item plain(input logic [7:0] c);
        t_byte_item r;
        r = '0;
        r.ch = c;
        return r;
    endfunction

    function automatic t_byte_item with_tok(input logic [7:0] c, input t_tok_type t,
                                            input int s, input int l, input int rw,
                                            input int cl);
        t_byte_item r;
        r.ch = c;
        r.typed = 1'b1;
        r.want = '{ttype: t, start: IDX_W'(s), len: 16'(l), row: POS_W'(rw),
                   col: POS_W'(cl), last: 1'b1};
        return r;
    endfunction

    task automatic reset_scan();
        sc_mode = MODE_IDLE;
        sc_word = '0;
        sc_wcount = '0;
        sc_index = '0;
        sc_row = 1;
        sc_col = 1;
        tk_start = '0;
        tk_row = 1;
        tk_col = 1;
    endtask

    task automatic emit(input t_tok_type t, input logic [IDX_W-1:0] s, input logic [15:0] l,
                        input logic [POS_W-1:0] rw, input logic [POS_W-1:0] cl);
        step_q.push_back('{ttype: t, start: s, len: l, row: rw, col: cl, last: 1'b0});
    endtask

    task automatic mark_here();
        tk_start = sc_index;
        tk_row = sc_row;
        tk_col = sc_col;
    endtask

    task automatic scan_idle(input logic [7:0] c, inout bit restart);
        t_tok_type pt;
        pt = punct_code(c);
        if (c == CH_NUL) begin
            restart = 1'b1;
            emit(KIND_END, sc_index, 16'd0, sc_row, sc_col);
        end else if (c == CH_SPACE || c == CH_TAB) begin
            sc_col = pos_next(sc_col);
        end else if (c == CH_LF) begin
            sc_col = 1;
            sc_row = pos_next(sc_row);
        end else if (c == CH_CR) begin
            sc_col = 1;
        end else if (is_letter(c)) begin
            mark_here();
            sc_word = {40'd0, c};
            sc_wcount = 3'd1;
            sc_mode = MODE_IDENT;
            sc_col = pos_next(sc_col);
        end else if (is_num(c)) begin
            mark_here();
            sc_mode = MODE_NUM;
            sc_col = pos_next(sc_col);
        end else if (c == CH_QUOTE) begin
            sc_col = pos_next(sc_col);
            tk_start = idx_next(sc_index);
            tk_row = sc_row;
            tk_col = sc_col;
            sc_mode = MODE_STR;
        end else if (c == CH_DASH) begin
            mark_here();
            sc_mode = MODE_MINUS;
            sc_col = pos_next(sc_col);
        end else if (pt != KIND_ERROR) begin
            emit(pt, sc_index, 16'd1, sc_row, sc_col);
            sc_col = pos_next(sc_col);
        end else begin
            sc_mode = MODE_DROP;
            emit(KIND_ERROR, sc_index, 16'd1, sc_row, sc_col);
        end
    endtask

    task automatic scan_byte(input logic [7:0] c);
        bit restart;
        restart = 1'b0;
        step_q.delete();
        case (sc_mode)
            MODE_IDENT: begin
                if (is_letter(c) || is_num(c)) begin
                    if (sc_wcount < 3'd6) begin
                        sc_word[8*sc_wcount +: 8] = c;
                        sc_wcount = sc_wcount + 3'd1;
                    end else begin
                        sc_wcount = 3'd7;
                    end
                    sc_col = pos_next(sc_col);
                end else begin
                    emit(word_code(), tk_start, span_len(sc_index), tk_row, tk_col);
                    sc_mode = MODE_IDLE;
                    sc_word = '0;
                    sc_wcount = '0;
                    scan_idle(c, restart);
                end
            end
            MODE_NUM: begin
                if (is_num(c)) begin
                    sc_col = pos_next(sc_col);
                end else begin
                    emit(KIND_NUM, tk_start, span_len(sc_index), tk_row, tk_col);
                    sc_mode = MODE_IDLE;
                    scan_idle(c, restart);
                end
            end
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    sc_col = pos_next(sc_col);
                    emit(KIND_STRING, tk_start, span_len(idx_next(sc_index)), tk_row, tk_col);
                    sc_mode = MODE_IDLE;
                end else if (c == CH_NUL) begin
                    emit(KIND_ERROR, tk_start, span_len(sc_index), tk_row, tk_col);
                    restart = 1'b1;
                end else begin
                    sc_col = pos_next(sc_col);
                end
            end
            MODE_MINUS: begin
                if (c == CH_GT) begin
                    sc_col = pos_next(sc_col);
                    emit(KIND_ARROW, tk_start, span_len(idx_next(sc_index)), tk_row, tk_col);
                    sc_mode = MODE_IDLE;
                end else begin
                    emit(KIND_MINUS, tk_start, 16'd1, tk_row, tk_col);
                    sc_mode = MODE_IDLE;
                    scan_idle(c, restart);
                end
            end
            MODE_DROP: begin
                if (c == CH_NUL) restart = 1'b1;
            end
            default: begin
                sc_mode = MODE_IDLE;
                scan_idle(c, restart);
            end
        endcase
        if (restart) reset_scan();
        else sc_index = idx_next(sc_index);
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    endtask

    // sender: offer bytes, predict tokens on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                scan_byte(cur_item.ch);
                if (cur_item.typed) token_q.push_back(cur_item.want);
                else foreach (step_q[k]) token_q.push_back(step_q[k]);
            end
            if (!i_valid || !o_stall) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item = byte_q.pop_front();
                    i_ch <= cur_item.ch;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endtask

    // receiver: check tokens, stall at random, one long hold-off
    always @(posedge i_clk) begin
        t_tok want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (token_q.size() == 0) begin
                    $error("token type %0d start %0d with no token pending",
                           o_token_type, o_token_start);
                    errs++;
                end else begin
                    want = token_q.pop_front();
                    cmp_field("token_type", want.ttype, o_token_type);
                    cmp_field("token_start", want.start, o_token_start);
                    cmp_field("token_length", want.len, o_token_length);
                    cmp_field("token_row", want.row, o_token_row);
                    cmp_field("token_col", want.col, o_token_col);
                    cmp_field("last", want.last, o_last);
                end
                out_count++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && out_count >= 150) begin
                hold_done = 1'b1;
                hold_left = 300;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    task automatic add_byte(input logic [7:0] c);
        byte_q.push_back(plain(c));
        rand_bytes++;
    endtask

    function automatic logic [7:0] rand_letter();
        return letters[$urandom_range(0, letters.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_str_byte();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return (c == CH_QUOTE) ? 8'h23 : c;
    endfunction

    task automatic gen_text();
        int    ntok;
        int    kind;
        int    n;
        int    fin;
        string kw;
        ntok = $urandom_range(1, 12);
        repeat (ntok) begin
            kind = $urandom_range(0, 39);
            if (kind < 6) begin
                n = $urandom_range(1, 9);
                add_byte(rand_letter());
                repeat (n - 1)
                    add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range("0", "9"))
                                                         : rand_letter());
            end else if (kind < 10) begin
                kw = kw_names[$urandom_range(0, 6)];
                for (int i = 0; i < kw.len(); i++) add_byte(kw[i]);
            end else if (kind < 14) begin
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range("0", "9")));
            end else if (kind < 18) begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(0, 8)) add_byte(rand_str_byte());
                add_byte(CH_QUOTE);
            end else if (kind < 24) begin
                add_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
            end else if (kind < 26) begin
                add_byte(CH_DASH);
            end else if (kind < 28) begin
                add_byte(CH_DASH);
                add_byte(CH_GT);
            end else if (kind < 39) begin
                case ($urandom_range(0, 5))
                    0: add_byte(CH_TAB);
                    1: add_byte(CH_CR);
                    2: add_byte(CH_LF);
                    default: add_byte(CH_SPACE);
                endcase
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end
        fin = $urandom_range(0, 19);
        if (fin == 17 || fin == 18) begin
            add_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) add_byte(rand_str_byte());
        end else if (fin == 19) begin
            add_byte(8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        add_byte(CH_NUL);
    endtask

    task automatic drain();
        while (byte_q.size() > 0 || i_valid) @(posedge i_clk);
        while (token_q.size() > 0) @(posedge i_clk);
    endtask

    t_byte_item dir_tab [25];

    initial begin
        int target;
        dir_tab = '{
            with_tok("(", KIND_LPAREN, 0, 1, 1, 1),
            with_tok("@", KIND_ERROR, 1, 1, 1, 2),
            plain(8'hFF),
            plain(CH_NUL),
            with_tok(CH_NUL, KIND_END, 0, 0, 1, 1),
            plain(CH_DASH),
            with_tok(CH_GT, KIND_ARROW, 0, 2, 1, 1),
            plain(CH_DASH),
            plain(CH_DASH),
            plain("x"),
            plain("9"),
            plain(CH_SPACE),
            plain(CH_TAB),
            plain(CH_CR),
            plain(CH_LF),
            plain(CH_QUOTE),
            plain(CH_LF),
            plain(CH_QUOTE),
            plain("7"),
            plain(CH_QUOTE),
            plain(CH_NUL),
            plain("i"),
            plain("f"),
            plain(";"),
            plain(CH_NUL)
        };
        reset_scan();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) byte_q.push_back(dir_tab[k]);
        drain();

        rand_bytes = 0;
        for (int chunk = 0; chunk < 4; chunk++) begin
            idle_pct = (chunk == 2) ? 0 : 33;
            target = rand_bytes + 475;
            while (rand_bytes < target) gen_text();
            drain();
        end
        idle_pct = 33;

        repeat (20) @(posedge i_clk);
        if (errs == 0 && token_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
